/* hdl/addressed_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// Addressed frame receiver assertion macros
// Clocked property shorthands used by the receiver datapath.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_FRAME_RECEIVER_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afr: same-cycle check failed");

// next-cycle implication, disabled in reset
`define AFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afr: next-cycle check failed");

`endif

/* hdl/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants of the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int FRAME_BYTES = 21;
    localparam int CNT_W       = 5;
    localparam int MAX_LEN     = FRAME_BYTES - 6;
    localparam int LEN_BIAS    = 5;
    localparam int LEN_POS     = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_SUM  = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERR,
        S_READ,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       line_error;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic       last;
    } t_out;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load_good;
        logic load_err;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic bad;
        logic out_free;
        logic last;
    } t_sts;

endpackage

/* hdl/afr_ctrl.sv */
// ----------------------------------------------------------------------------
// afr_ctrl
// Sequencer: takes words while idle, then reports a finished frame.
// ----------------------------------------------------------------------------
module afr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  afr_pkg::t_sts   i_sts,
    output afr_pkg::t_cmd   o_cmd
);

    afr_pkg::t_state r_state;
    afr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            afr_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.done) begin
                    n_state = i_sts.bad ? afr_pkg::S_ERR : afr_pkg::S_READ;
                end
            end
            afr_pkg::S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = afr_pkg::S_IDLE;
                end
            end
            afr_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = afr_pkg::S_PUSH;
            end
            afr_pkg::S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_good = 1'b1;
                    n_state = i_sts.last ? afr_pkg::S_IDLE : afr_pkg::S_READ;
                end
            end
            default: begin
                n_state = afr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/afr_dp.sv */
// ----------------------------------------------------------------------------
// afr_dp
// Frame store, byte count, running sum, idle timer and output register.
// ----------------------------------------------------------------------------
`include "addressed_frame_receiver_assert.svh"

module afr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  afr_pkg::t_in                    i_in_data,
    input  afr_pkg::t_cmd                   i_cmd,
    output afr_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output afr_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    logic [7:0] r_mem [afr_pkg::FRAME_BYTES];

    logic [7:0]                r_dev_addr;
    logic [7:0]                r_timeout;
    logic [afr_pkg::CNT_W-1:0] r_cnt;
    logic [afr_pkg::CNT_W-1:0] n_cnt;
    logic [7:0]                r_timer;
    logic [7:0]                n_timer;
    logic [7:0]                r_len;
    logic [7:0]                r_sum;
    logic [1:0]                r_status;
    logic [afr_pkg::CNT_W-1:0] r_n;
    logic [afr_pkg::CNT_W-1:0] r_idx;
    logic [7:0]                r_rd_data;
    logic                      r_out_valid;
    afr_pkg::t_out             r_out;

    logic [afr_pkg::CNT_W-1:0] w_cnt_inc;
    logic                      w_store;
    logic                      w_first;
    logic                      w_done;
    logic [1:0]                w_code;
    logic                      w_last;
    logic [7:0]                w_limit;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd0;
            r_timeout  <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afr_pkg::CFG_DEV_ADDR: r_dev_addr <= i_cfg_data;
                afr_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cnt_inc = r_cnt + afr_pkg::CNT_W'(1);
    assign w_limit   = r_timeout - 8'd1;

    // word decode
    always_comb begin
        n_cnt   = r_cnt;
        n_timer = r_timer;
        w_store = 1'b0;
        w_first = 1'b0;
        w_done  = 1'b0;
        w_code  = afr_pkg::ST_GOOD;
        if (i_in_data.op == afr_pkg::OP_TICK) begin
            if (r_timer == w_limit) begin
                n_timer = r_timeout;
                n_cnt   = '0;
            end else if (r_timer != r_timeout) begin
                n_timer = r_timer + 8'd1;
            end
        end else begin
            n_timer = 8'd0;
            if (!i_in_data.line_error) begin
                if (r_cnt == '0) begin
                    if (i_in_data.rx_byte == r_dev_addr) begin
                        w_first = 1'b1;
                        n_cnt   = afr_pkg::CNT_W'(1);
                    end
                end else if (r_cnt >= afr_pkg::CNT_W'(afr_pkg::FRAME_BYTES)) begin
                    n_cnt = '0;
                end else begin
                    w_store = 1'b1;
                    n_cnt   = w_cnt_inc;
                    if (w_cnt_inc >= afr_pkg::CNT_W'(afr_pkg::LEN_BIAS) &&
                        (({4'd0, w_cnt_inc} == ({1'b0, r_len} + 9'(afr_pkg::LEN_BIAS))) ||
                         w_cnt_inc == afr_pkg::CNT_W'(afr_pkg::FRAME_BYTES))) begin
                        w_done = 1'b1;
                        n_cnt  = '0;
                        if (r_len > 8'(afr_pkg::MAX_LEN)) begin
                            w_code = afr_pkg::ST_LEN;
                        end else if (i_in_data.rx_byte != r_sum) begin
                            w_code = afr_pkg::ST_SUM;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_timer <= 8'd0;
        end else if (i_cmd.accept) begin
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
        end
    end

    // store, length, running sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_first) begin
            r_mem[0] <= i_in_data.rx_byte;
            r_sum    <= i_in_data.rx_byte;
        end
        if (i_cmd.accept && w_store) begin
            r_mem[r_cnt] <= i_in_data.rx_byte;
            r_sum        <= r_sum + i_in_data.rx_byte;
            if (r_cnt == afr_pkg::CNT_W'(afr_pkg::LEN_POS)) begin
                r_len <= i_in_data.rx_byte;
            end
        end
        if (i_cmd.accept && w_done) begin
            r_status <= w_code;
            r_n      <= afr_pkg::CNT_W'(r_len) + afr_pkg::CNT_W'(afr_pkg::LEN_BIAS - 1);
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign w_last = (r_idx == r_n - afr_pkg::CNT_W'(1));

    // report index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_good) begin
            r_idx <= w_last ? '0 : r_idx + afr_pkg::CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_good || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_good) begin
            r_out.status     <= afr_pkg::ST_GOOD;
            r_out.frame_byte <= r_rd_data;
            r_out.byte_index <= r_idx;
            r_out.last       <= w_last;
        end else if (i_cmd.load_err) begin
            r_out.status     <= r_status;
            r_out.frame_byte <= 8'd0;
            r_out.byte_index <= '0;
            r_out.last       <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_sts.done     = w_done;
    assign o_sts.bad      = (w_code != afr_pkg::ST_GOOD);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last     = w_last;

    `AFR_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < afr_pkg::CNT_W'(afr_pkg::FRAME_BYTES))
    `AFR_ASSERT_IMP(a_one_load, i_clk, i_rst_n, i_cmd.load_good, !i_cmd.load_err)
    `AFR_ASSERT_IMP(a_rd_in_frame, i_clk, i_rst_n, i_cmd.rd, r_idx < r_n)
    `AFR_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_cmd.load_good || i_cmd.load_err, r_out_valid)

endmodule

/* hdl/addressed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Deframes addressed multidrop packets with an 8-bit sum and streams them out.
// ----------------------------------------------------------------------------
// Sequence: a good frame's closing byte leads to a read state, which registers
// a frame store byte, then to a push state, which loads the output register once
// it is free; a bad frame waits in an error state for a free output register.
// Throughput: one input word per cycle while idle; none is taken during readout.
// Reset: synchronous active low; clears count, timer, sequencer and output
// valid; device address resets to 0 and timeout to 10.
module addressed_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  afr_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output afr_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    afr_pkg::t_cmd w_cmd;
    afr_pkg::t_sts w_sts;

    afr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    afr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
